FILE: rtl/ssd_pkg.sv
// shared types, constants and helpers of the two-wire seven-segment display driver
// no dependencies; used by every module of the block
package ssd_pkg;

	// digit count: default and supported maximum
	localparam int unsigned DIGIT_COUNT_DEF = 4;
	localparam int unsigned MAX_DIGITS = 6;

	// input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_DATA_CMD = 2'd0;
	localparam logic [1:0] REG_ADDR_CMD = 2'd1;
	localparam logic [1:0] REG_DISP_CTRL = 2'd2;

	localparam logic [7:0] DATA_CMD_RST = 8'h40;
	localparam logic [7:0] ADDR_CMD_RST = 8'hC0;
	localparam logic [7:0] DISP_CTRL_RST = 8'h8F;

	// frame codes
	localparam logic [1:0] FRAME_DATA = 2'd0;
	localparam logic [1:0] FRAME_ADDR = 2'd1;
	localparam logic [1:0] FRAME_CTRL = 2'd2;

	// sequencer phase codes
	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_BYTE = 2'd1;
	localparam logic [1:0] PH_STOP = 2'd2;

	// bit slot counter value of the ack slot
	localparam logic [3:0] ACK_SLOT = 4'd8;

	// reciprocal multipliers and shifts for n / 10^k, exact for any 16-bit n
	localparam logic [16:0] RECIP_MUL [0:MAX_DIGITS] = '{
		17'd1, 17'd104858, 17'd83887, 17'd67109, 17'd107375, 17'd0, 17'd0
	};
	localparam int unsigned RECIP_SHIFT [0:MAX_DIGITS] = '{0, 20, 23, 26, 30, 0, 0};

	typedef struct packed {
		logic        command;
		logic [15:0] number;
	} in_item_t;

	typedef struct packed {
		logic clock_line;
		logic data_line;
		logic data_drive;
		logic busy_res;
		logic sequence_done;
	} out_item_t;

	typedef struct packed {
		logic [7:0] data_command;
		logic [7:0] address_command;
		logic [7:0] display_control;
	} cfg_regs_t;

	// decimal digit to segment pattern, colon bit left clear
	function automatic logic [6:0] seg_code(input logic [3:0] digit);
		logic [6:0] code;
		case (digit)
			4'd0: code = 7'h3F;
			4'd1: code = 7'h06;
			4'd2: code = 7'h5B;
			4'd3: code = 7'h4F;
			4'd4: code = 7'h66;
			4'd5: code = 7'h6D;
			4'd6: code = 7'h7D;
			4'd7: code = 7'h07;
			4'd8: code = 7'h7F;
			4'd9: code = 7'h6F;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

endpackage

FILE: rtl/ssd_digit_split.sv
// quotients of a 16-bit number by the powers of ten, by reciprocal multiplication
// depends on ssd_pkg
module ssd_digit_split #(
	parameter int unsigned DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
	input  logic [15:0]                  number,
	output logic [DIGIT_COUNT:0][15:0]   quot
);

	for (genvar k = 0; k <= DIGIT_COUNT; k++) begin : g_quot
		localparam logic [16:0] MUL = ssd_pkg::RECIP_MUL[k];
		localparam int unsigned SH = ssd_pkg::RECIP_SHIFT[k];
		logic [32:0] prod;
		logic [32:0] shifted;

		assign prod = {17'd0, number} * {16'd0, MUL};
		assign shifted = prod >> SH;
		assign quot[k] = shifted[15:0];
	end

endmodule

FILE: rtl/ssd_frame_seq.sv
// frame sequencer: plays one pin step per tick and holds the pin levels
// depends on ssd_pkg
module ssd_frame_seq #(
	parameter int unsigned DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic                              command,
	input  ssd_pkg::cfg_regs_t                cfg,
	input  logic [DIGIT_COUNT-1:0][6:0]       segments,
	output logic                              running,
	output ssd_pkg::out_item_t                result
);

	localparam int unsigned BW = $clog2(DIGIT_COUNT + 1);

	logic          running_q;
	logic [1:0]    frame_q;
	logic [1:0]    phase_q;
	logic [1:0]    sub_q;
	logic [3:0]    bit_q;
	logic [BW-1:0] byte_q;
	logic          clock_q;
	logic          data_q;
	logic          drive_q;

	logic          clock_n;
	logic          data_n;
	logic          drive_n;
	logic [1:0]    frame_n;
	logic [1:0]    phase_n;
	logic [1:0]    sub_n;
	logic [3:0]    bit_n;
	logic [BW-1:0] byte_n;
	logic          play;
	logic          seq_last;
	logic          last_byte;
	logic [7:0]    tx_byte;
	logic          tx_bit;
	logic [7:0]    addr_bytes [0:DIGIT_COUNT];

	assign play = (command == ssd_pkg::CMD_TICK) && running_q;
	assign running = running_q;

	// address frame: address command, then the digit bytes
	assign addr_bytes[0] = cfg.address_command;
	for (genvar i = 1; i <= DIGIT_COUNT; i++) begin : g_bytes
		assign addr_bytes[i] = {1'b0, segments[i-1]};
	end

	always_comb begin
		case (frame_q)
			ssd_pkg::FRAME_DATA: tx_byte = cfg.data_command;
			ssd_pkg::FRAME_CTRL: tx_byte = cfg.display_control;
			default:             tx_byte = addr_bytes[byte_q];
		endcase
	end

	assign tx_bit = tx_byte[bit_q[2:0]];
	assign last_byte = (frame_q == ssd_pkg::FRAME_ADDR) ? (byte_q == BW'(DIGIT_COUNT))
		: (byte_q == '0);
	assign seq_last = (frame_q == ssd_pkg::FRAME_CTRL) && (phase_q == ssd_pkg::PH_STOP)
		&& (sub_q == 2'd3);

	// pin levels after this step
	always_comb begin
		clock_n = clock_q;
		data_n = data_q;
		drive_n = drive_q;
		case (phase_q)
			ssd_pkg::PH_START: begin
				case (sub_q)
					2'd0: clock_n = 1'b1;
					2'd1: begin
						data_n = 1'b1;
						drive_n = 1'b1;
					end
					default: data_n = 1'b0;
				endcase
			end
			ssd_pkg::PH_BYTE: begin
				if (bit_q == ssd_pkg::ACK_SLOT) begin
					case (sub_q)
						2'd0: begin
							clock_n = 1'b0;
							drive_n = 1'b0;
						end
						2'd1: clock_n = 1'b1;
						default: begin
							clock_n = 1'b0;
							drive_n = 1'b1;
						end
					endcase
				end else begin
					case (sub_q)
						2'd0: clock_n = 1'b0;
						2'd1: data_n = tx_bit;
						default: clock_n = 1'b1;
					endcase
				end
			end
			default: begin
				case (sub_q)
					2'd0: clock_n = 1'b0;
					2'd1: data_n = 1'b0;
					2'd2: clock_n = 1'b1;
					default: data_n = 1'b1;
				endcase
			end
		endcase
	end

	// position of the next step
	always_comb begin
		frame_n = frame_q;
		phase_n = phase_q;
		sub_n = sub_q + 2'd1;
		bit_n = bit_q;
		byte_n = byte_q;
		case (phase_q)
			ssd_pkg::PH_START: begin
				if (sub_q == 2'd2) begin
					phase_n = ssd_pkg::PH_BYTE;
					sub_n = 2'd0;
					bit_n = 4'd0;
					byte_n = '0;
				end
			end
			ssd_pkg::PH_BYTE: begin
				if (sub_q == 2'd2) begin
					sub_n = 2'd0;
					if (bit_q == ssd_pkg::ACK_SLOT) begin
						bit_n = 4'd0;
						if (last_byte) begin
							phase_n = ssd_pkg::PH_STOP;
						end else begin
							byte_n = byte_q + BW'(1);
						end
					end else begin
						bit_n = bit_q + 4'd1;
					end
				end
			end
			default: begin
				if (sub_q == 2'd3) begin
					frame_n = (frame_q == ssd_pkg::FRAME_CTRL) ? ssd_pkg::FRAME_DATA
						: frame_q + 2'd1;
					phase_n = ssd_pkg::PH_START;
					sub_n = 2'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			frame_q <= ssd_pkg::FRAME_DATA;
			phase_q <= ssd_pkg::PH_START;
			sub_q <= 2'd0;
			bit_q <= 4'd0;
			byte_q <= '0;
			clock_q <= 1'b0;
			data_q <= 1'b0;
			drive_q <= 1'b1;
		end else if (fire) begin
			if (command == ssd_pkg::CMD_LOAD) begin
				if (!running_q) begin
					running_q <= 1'b1;
					frame_q <= ssd_pkg::FRAME_DATA;
					phase_q <= ssd_pkg::PH_START;
					sub_q <= 2'd0;
					bit_q <= 4'd0;
					byte_q <= '0;
				end
			end else if (play) begin
				clock_q <= clock_n;
				data_q <= data_n;
				drive_q <= drive_n;
				frame_q <= frame_n;
				phase_q <= phase_n;
				sub_q <= sub_n;
				bit_q <= bit_n;
				byte_q <= byte_n;
				if (seq_last) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		result.clock_line = play ? clock_n : clock_q;
		result.data_line = play ? data_n : data_q;
		result.data_drive = play ? drive_n : drive_q;
		result.busy_res = (command == ssd_pkg::CMD_LOAD) || running_q;
		result.sequence_done = play && seq_last;
	end

endmodule

FILE: rtl/seven_segment_two_wire_display_driver.sv
// top level of the two-wire seven-segment display driver
// depends on ssd_pkg, ssd_digit_split and ssd_frame_seq
//
// usage:
//   in channel (in_valid/in_ready/in_data): each request is a load (command 0)
//   carrying a 16-bit number, or a tick (command 1). a load while idle splits
//   the number into DIGIT_COUNT decimal digits and starts the three frames
//   (data command; address command plus digit bytes; display control); a load
//   while busy is dropped but still answered. each tick plays one pin step,
//   21 + 27 * (DIGIT_COUNT + 3) ticks per sequence (210 for four digits).
//   out channel (out_valid/out_ready/out_data): one result per request, with
//   the pin levels after that request, busy and the done flag of the last step.
//   a taken request passes through the input register, then the result register.
//   throughput: one request per cycle while the receiver does not stall.
//   a stalled receiver holds the result; one more request waits in the input
//   register, then in_ready drops until the receiver takes the result.
//   cfg port: cfg_write with cfg_index / cfg_data sets a command byte; write
//   only while idle. unknown indexes are ignored.
//   reset: clock and data pins low, data driven, sequencer idle, command
//   bytes back to their defaults; digit patterns are unknown until a load.
module seven_segment_two_wire_display_driver #(
	parameter int unsigned DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ssd_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ssd_pkg::out_item_t  out_data,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	// input register: command plus the quotients by the powers of ten
	logic                        valid_s1;
	logic                        command_s1;
	logic [DIGIT_COUNT:0][15:0]  quot_s1;
	logic [DIGIT_COUNT:0][15:0]  quot;

	// config bytes and digit patterns
	ssd_pkg::cfg_regs_t          cfg_q;
	logic [DIGIT_COUNT-1:0][6:0] seg_q;

	// result register
	logic                        out_valid_q;
	ssd_pkg::out_item_t          out_data_q;

	logic                        advance;
	logic                        running;
	logic                        load_take;
	ssd_pkg::out_item_t          result;
	logic [DIGIT_COUNT-1:0][3:0] digit;

	// the stage moves whenever the result register is free or being drained
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	ssd_digit_split #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_split (
		.number(in_data.number),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= in_data.command;
			quot_s1 <= quot;
		end
	end

	// digit k = q(k) - 10 * q(k+1)
	for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
		logic [15:0] tens;
		logic [15:0] diff;

		assign tens = {quot_s1[k+1][12:0], 3'b000} + {quot_s1[k+1][14:0], 1'b0};
		assign diff = quot_s1[k] - tens;
		assign digit[k] = diff[3:0];
	end

	// config writes; the user must write only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_command <= ssd_pkg::DATA_CMD_RST;
			cfg_q.address_command <= ssd_pkg::ADDR_CMD_RST;
			cfg_q.display_control <= ssd_pkg::DISP_CTRL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ssd_pkg::REG_DATA_CMD:  cfg_q.data_command <= cfg_data;
				ssd_pkg::REG_ADDR_CMD:  cfg_q.address_command <= cfg_data;
				ssd_pkg::REG_DISP_CTRL: cfg_q.display_control <= cfg_data;
				default: ;
			endcase
		end
	end

	// a load accepted while idle refreshes all digit patterns, most significant first
	assign load_take = advance && (command_s1 == ssd_pkg::CMD_LOAD) && !running;

	always_ff @(posedge clk) begin
		if (load_take) begin
			for (int j = 0; j < DIGIT_COUNT; j++) begin
				seg_q[j] <= ssd_pkg::seg_code(digit[DIGIT_COUNT-1-j]);
			end
		end
	end

	ssd_frame_seq #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.command (command_s1),
		.cfg     (cfg_q),
		.segments(seg_q),
		.running (running),
		.result  (result)
	);

	// result register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

endmodule

FILE: rtl/ssd_checker.sv
// port-level checks of the two-wire seven-segment display driver, bound to the top
// depends on ssd_pkg and seven_segment_two_wire_display_driver
module ssd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input ssd_pkg::out_item_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an empty output side never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// the final step leaves both lines high with data driven
	a_done_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sequence_done |->
		out_data.busy_res && out_data.clock_line && out_data.data_line
		&& out_data.data_drive)
		else $error("bad line levels on final step");

	// the data pin is only released inside a running sequence
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.data_drive |-> out_data.busy_res)
		else $error("data released while idle");

endmodule

bind seven_segment_two_wire_display_driver ssd_checker u_ssd_checker (.*);
